FILE: rtl/core/tnd_pkg.sv
// Telnet protocol codes and register indexes for the command deframer.
// No dependencies; imported by the top level and by its checker.
`timescale 1ns / 1ps

package tnd_pkg;

    localparam logic [7:0] TN_IAC  = 8'hff;
    localparam logic [7:0] TN_DONT = 8'hfe;
    localparam logic [7:0] TN_DO   = 8'hfd;
    localparam logic [7:0] TN_WONT = 8'hfc;
    localparam logic [7:0] TN_WILL = 8'hfb;
    localparam logic [7:0] TN_SB   = 8'hfa;
    localparam logic [7:0] TN_SE   = 8'hf0;

    localparam logic [7:0] OPTION_ECHO    = 8'd1;
    localparam logic [7:0] OPTION_SGA     = 8'd3;
    localparam logic [7:0] OPTION_WINSIZE = 8'd31;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic [15:0] COLUMNS_RESET = 16'd80;
    localparam logic [15:0] ROWS_RESET    = 16'd24;
    localparam logic [15:0] COLUMNS_MIN   = 16'd8;
    localparam logic [15:0] ROWS_MIN      = 16'd1;

    // Kind of output run held in the result register.
    typedef logic [1:0] t_kind;
    localparam t_kind K_DATA  = 2'd0;
    localparam t_kind K_REPLY = 2'd1;
    localparam t_kind K_NAWS  = 2'd2;

endpackage

FILE: rtl/core/telnet_command_deframer_negotiator.sv
// Telnet receive deframer and option negotiator: parses IAC sequences and
// sequences the terminal data bytes and negotiation replies.
// Depends on tnd_pkg.
// Latency: the first result beat is offered in the cycle after its byte is accepted.
// Throughput: a data byte gives one beat, an ordinary reply three and a DO NAWS reply
// 12 to 16, one beat per cycle from the output sequencer while the sink is ready.
// Bytes that give no result load no run. The next byte is taken as the last beat goes.
// Reset (synchronous, active low) returns the parser to the data state, drops
// any run in progress and restores the window geometry to 80 by 24.
`timescale 1ns / 1ps

module telnet_command_deframer_negotiator
    import tnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] peer_closed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] destination
    output logic        m_axis_tlast
);

    localparam logic [2:0] PS_DATA  = 3'd0;
    localparam logic [2:0] PS_IAC   = 3'd1;
    localparam logic [2:0] PS_NEG   = 3'd2;
    localparam logic [2:0] PS_SB    = 3'd3;
    localparam logic [2:0] PS_SBIAC = 3'd4;

    localparam logic [3:0] STEP_REPLY_LAST = 4'd2;
    localparam logic [3:0] STEP_COLS_HI    = 4'd6;
    localparam logic [3:0] STEP_COLS_LO    = 4'd7;
    localparam logic [3:0] STEP_ROWS_HI    = 4'd8;
    localparam logic [3:0] STEP_ROWS_LO    = 4'd9;
    localparam logic [3:0] STEP_NAWS_LAST  = 4'd11;

    logic [15:0] r_cols;
    logic [15:0] r_rows;
    logic [2:0]  r_state, n_state;
    logic [7:0]  r_pend,  n_pend;
    logic        r_sbopt, n_sbopt;

    logic        r_job_valid;
    t_kind       r_kind,  n_kind;
    logic [7:0]  r_cmd,   n_cmd;
    logic [7:0]  r_opt,   n_opt;
    logic [3:0]  r_step;
    logic        r_dup;

    logic        w_load;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_last;
    logic        w_need_dup;
    logic [7:0]  w_byte;
    logic [15:0] w_cols;
    logic [15:0] w_rows;
    logic [7:0]  c;
    logic        closed;

    assign c      = s_axis_tdata;
    assign closed = s_axis_tuser;

    assign w_cols = (r_cols < COLUMNS_MIN) ? COLUMNS_MIN : r_cols;
    assign w_rows = (r_rows < ROWS_MIN) ? ROWS_MIN : r_rows;

    // Output sequencer: the run is selected by kind and step.
    always_comb begin
        w_byte     = TN_IAC;
        w_last     = 1'b0;
        w_need_dup = 1'b0;
        case (r_kind)
            K_DATA: begin
                w_byte = r_opt;
                w_last = 1'b1;
            end
            K_REPLY, K_NAWS: begin
                case (r_step)
                    4'd0:         w_byte = TN_IAC;
                    4'd1:         w_byte = r_cmd;
                    4'd2:         w_byte = r_opt;
                    4'd3:         w_byte = TN_IAC;
                    4'd4:         w_byte = TN_SB;
                    4'd5:         w_byte = OPTION_WINSIZE;
                    STEP_COLS_HI: w_byte = w_cols[15:8];
                    STEP_COLS_LO: w_byte = w_cols[7:0];
                    STEP_ROWS_HI: w_byte = w_rows[15:8];
                    STEP_ROWS_LO: w_byte = w_rows[7:0];
                    4'd10:        w_byte = TN_IAC;
                    4'd11:        w_byte = TN_SE;
                    default:      w_byte = TN_IAC;
                endcase
                if (r_kind == K_REPLY) begin
                    w_last = (r_step == STEP_REPLY_LAST);
                end else begin
                    w_last = (r_step == STEP_NAWS_LAST);
                    // A size byte of 0xFF is sent twice.
                    w_need_dup = (r_step >= STEP_COLS_HI) && (r_step <= STEP_ROWS_LO)
                                 && (w_byte == TN_IAC) && !r_dup;
                end
            end
            default: begin
                w_byte = TN_IAC;
                w_last = 1'b1;
            end
        endcase
    end

    assign m_axis_tvalid = r_job_valid;
    assign m_axis_tdata  = w_byte;
    assign m_axis_tuser  = (r_kind != K_DATA);
    assign m_axis_tlast  = w_last;

    assign w_out_acc     = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !r_job_valid || (w_out_acc && w_last);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Parser: next state and the run to be loaded for the accepted byte.
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_sbopt = r_sbopt;
        w_load  = 1'b0;
        n_kind  = K_DATA;
        n_cmd   = TN_WONT;
        n_opt   = c;
        unique case (r_state)
            PS_IAC: begin
                if (c == TN_IAC) begin
                    n_state = PS_DATA;
                end else if (c inside {TN_WILL, TN_WONT, TN_DO, TN_DONT}) begin
                    n_pend  = c;
                    n_state = PS_NEG;
                end else if (c == TN_SB) begin
                    n_sbopt = 1'b0;
                    n_state = PS_SB;
                end else begin
                    n_state = PS_DATA;
                end
            end
            PS_NEG: begin
                n_state = PS_DATA;
                n_kind  = K_REPLY;
                if (r_pend == TN_WILL) begin
                    w_load = !closed;
                    n_cmd  = (c == OPTION_ECHO || c == OPTION_SGA) ? TN_DO : TN_DONT;
                end else if (r_pend == TN_DO) begin
                    w_load = !closed;
                    if (c == OPTION_SGA) begin
                        n_cmd = TN_WILL;
                    end else if (c == OPTION_WINSIZE) begin
                        n_cmd  = TN_WILL;
                        n_kind = K_NAWS;
                    end else begin
                        n_cmd = TN_WONT;
                    end
                end
            end
            PS_SB: begin
                if (!r_sbopt) begin
                    n_sbopt = 1'b1;
                end else if (c == TN_IAC) begin
                    n_state = PS_SBIAC;
                end
            end
            PS_SBIAC: begin
                if (c == TN_SE) begin
                    n_state = PS_DATA;
                    n_sbopt = 1'b0;
                end else begin
                    n_state = PS_SB;
                end
            end
            default: begin
                if (c == TN_IAC) begin
                    n_state = PS_IAC;
                end else begin
                    n_state = PS_DATA;
                    w_load  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLUMNS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_COLUMNS: r_cols <= i_cfg_wdata;
                CFG_ROWS:    r_rows <= i_cfg_wdata;
                default:     r_cols <= r_cols;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_DATA;
            r_pend  <= 8'd0;
            r_sbopt <= 1'b0;
        end else if (w_in_acc) begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_sbopt <= n_sbopt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_step      <= 4'd0;
            r_dup       <= 1'b0;
        end else if (w_in_acc && w_load) begin
            r_job_valid <= 1'b1;
            r_step      <= 4'd0;
            r_dup       <= 1'b0;
        end else if (w_out_acc) begin
            if (w_last) begin
                r_job_valid <= 1'b0;
            end else if (w_need_dup) begin
                r_dup <= 1'b1;
            end else begin
                r_step <= r_step + 4'd1;
                r_dup  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_load) begin
            r_kind <= n_kind;
            r_cmd  <= n_cmd;
            r_opt  <= n_opt;
        end
    end

endmodule

FILE: rtl/core/tnd_checker.sv
// Port-level checker for the Telnet command deframer, with its bind.
// Depends on tnd_pkg and on the top level's port names.
`timescale 1ns / 1ps

module tnd_checker
    import tnd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // High while the next output beat opens a new run.
    logic r_run_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_start <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_run_start <= m_axis_tlast;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_data_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && r_run_start)
        else $error("terminal data beat not a single-beat run");

    a_reply_opens_iac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser && r_run_start |-> m_axis_tdata == TN_IAC)
        else $error("reply run does not open with IAC");

    // Checked at the first edge after reset is released.
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind telnet_command_deframer_negotiator tnd_checker u_tnd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
